[sv/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define CSTK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Checked at every edge, reset included.
`define CSTK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CSTK_ASSERT(lbl, clk, rstn, prop)
`define CSTK_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[sv/cstk_pkg.sv]
// Types and constants of the stacking tower unit.
`default_nettype none
package cstk_pkg;
    localparam int DEF_MAX_ITEMS = 1024;
    localparam int TQ_DEPTH      = 2;

    typedef struct packed {
        logic [23:0] item_weight;
        logic [23:0] item_strength;
        logic        last_item;
    } t_in_item;

    typedef struct packed {
        logic [10:0] stack_count;
        logic        overflow;
    } t_out_item;

    // classified request between front and back
    typedef struct packed {
        t_in_item item;
        logic     store;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;
endpackage
`default_nettype wire

[sv/capacity_stack_max_count_unit.sv]
// Top level of the stacking tower unit.
`default_nettype none
`include "assert_macros.svh"
// Stacking tower unit. Items (weight, strength) are pushed while full is low and are
// kept in a store ordered by ascending strength; each request is inserted as it comes,
// one step per stored item of greater strength (each step one read and one write of
// the store). The request flagged last_item starts the height sweep: for item i of n
// the least-weight-per-height table is walked from height i+1 down to 1, one height
// per cycle through the table's read/write port. The result (greatest stackable
// height and whether the set overflowed MaxItems) then waits in an output register
// read through empty/pop; a two-entry request queue lets pushes land while the back
// end is busy. Requests beyond MaxItems are dropped and flag overflow. No clearing
// pass after reset is needed.
module capacity_stack_max_count_unit import cstk_pkg::*; #(
    parameter int MaxItems = DEF_MAX_ITEMS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_item,
    input  wire logic     pop,
    output logic          empty,
    output t_out_item     o_result
);
    t_task      front_task;
    t_task      q_task;
    t_fifo_stat q_stat;
    logic       q_pop;
    logic       out_valid;
    logic       accept;

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;
    assign empty  = !out_valid;

    cstk_front #(.MaxItems(MaxItems)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_task   (front_task)
    );

    cstk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_task),
        .i_pop   (q_pop),
        .o_data  (q_task),
        .o_stat  (q_stat)
    );

    cstk_back #(.MaxItems(MaxItems)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task       (q_task),
        .i_task_valid (!q_stat.empty),
        .o_task_pop   (q_pop),
        .i_out_pop    (pop),
        .o_out_valid  (out_valid),
        .o_out        (o_result)
    );

    // reset leaves no result pending
    `CSTK_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty)
    // queue cannot be full and empty at once
    `CSTK_ASSERT(a_q_stat, i_clk, i_rst_n, !(q_stat.full && q_stat.empty))
    // back end only pops a request that is there
    `CSTK_ASSERT(a_q_pop, i_clk, i_rst_n, q_pop |-> !q_stat.empty)
endmodule
`default_nettype wire

[sv/cstk_front.sv]
// Front end: tracks the set fill and marks requests as stored or overflowing.
`default_nettype none
module cstk_front import cstk_pkg::*; #(
    parameter int MaxItems = DEF_MAX_ITEMS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output t_task         o_task
);
    localparam int CW = $clog2(MaxItems + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          store;

    assign store = (r_cnt < CW'(MaxItems));
    assign o_task = '{item: i_item, store: store};

    always_comb begin
        n_cnt = r_cnt;
        if (i_accept) begin
            if (i_item.last_item) begin
                n_cnt = '0;
            end else if (store) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

[sv/cstk_fifo.sv]
// Short request queue between front and back.
`default_nettype none
module cstk_fifo import cstk_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_task i_data,
    input  wire logic  i_pop,
    output t_task      o_data,
    output t_fifo_stat o_stat
);
    localparam int PW = (TQ_DEPTH > 1) ? $clog2(TQ_DEPTH) : 1;
    localparam int NW = $clog2(TQ_DEPTH + 1);

    t_task         r_mem [TQ_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_n;
    logic          do_push;
    logic          do_pop;

    assign o_stat  = '{full: (r_n == NW'(TQ_DEPTH)), empty: (r_n == '0)};
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n  <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(TQ_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(TQ_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_n <= r_n + NW'(1);
            end else if (do_pop && !do_push) begin
                r_n <= r_n - NW'(1);
            end
        end
    end
endmodule
`default_nettype wire

[sv/cstk_back.sv]
// Back end: sorted insertion, height sweep and result register.
`default_nettype none
module cstk_back import cstk_pkg::*; #(
    parameter int MaxItems = DEF_MAX_ITEMS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_task i_task,
    input  wire logic  i_task_valid,
    output logic       o_task_pop,
    input  wire logic  i_out_pop,
    output logic       o_out_valid,
    output t_out_item  o_out
);
    localparam int AW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
    localparam int CW = $clog2(MaxItems + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INS_RD = 4'd1;
    localparam logic [3:0] S_INS_CM = 4'd2;
    localparam logic [3:0] S_RUN    = 4'd3;
    localparam logic [3:0] S_LD     = 4'd4;
    localparam logic [3:0] S_LD2    = 4'd5;
    localparam logic [3:0] S_SWEEP  = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [23:0]   r_w, n_w;
    logic [23:0]   r_s, n_s;
    logic          r_last, n_last;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [24:0]   r_cur, n_cur;
    logic [CW-1:0] r_best, n_best;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    // sorted item store {weight, strength}
    logic [47:0]   r_store [MaxItems];
    logic [47:0]   r_store_q;
    logic [AW-1:0] st_ra, st_wa;
    logic          st_we;
    logic [47:0]   st_wd;

    // least weight per height {valid, weight}
    logic [24:0]   r_dp [MaxItems + 1];
    logic [24:0]   r_dp_q;
    logic [CW-1:0] dp_ra, dp_wa;
    logic          dp_we;
    logic [24:0]   dp_wd;

    logic [24:0]      sum;
    logic             better;
    logic [24:0]      dp_new;
    logic [CW+10:0]   best_wide;

    assign sum    = {1'b0, r_dp_q[23:0]} + {1'b0, r_w};
    assign better = r_dp_q[24] && (sum <= {1'b0, r_s})
                    && (!r_cur[24] || (sum[23:0] < r_cur[23:0]));
    assign dp_new = better ? {1'b1, sum[23:0]} : r_cur;
    assign best_wide = (CW + 11)'(r_best);

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_wa] <= st_wd;
        end
        r_store_q <= r_store[st_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dp_we) begin
            r_dp[dp_wa] <= dp_wd;
        end
        r_dp_q <= r_dp[dp_ra];
    end

    always_comb begin
        n_state = r_state;   n_count = r_count;   n_ovf = r_ovf;
        n_w = r_w;           n_s = r_s;           n_last = r_last;
        n_k = r_k;           n_i = r_i;           n_j = r_j;
        n_cur = r_cur;       n_best = r_best;
        n_out_valid = r_out_valid && !i_out_pop;
        n_out = r_out;
        o_task_pop = 1'b0;
        st_ra = '0; st_wa = '0; st_we = 1'b0; st_wd = '0;
        dp_ra = '0; dp_wa = '0; dp_we = 1'b0; dp_wd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_task_valid) begin
                    o_task_pop = 1'b1;
                    n_w    = i_task.item.item_weight;
                    n_s    = i_task.item.item_strength;
                    n_last = i_task.item.last_item;
                    if (i_task.store) begin
                        n_k     = r_count[AW-1:0];
                        n_state = S_INS_RD;
                    end else begin
                        n_ovf   = 1'b1;
                        n_state = i_task.item.last_item ? S_RUN : S_IDLE;
                    end
                end
            end
            S_INS_RD: begin
                if (r_k == '0) begin
                    st_we   = 1'b1;
                    st_wd   = {r_w, r_s};
                    n_count = r_count + CW'(1);
                    n_state = r_last ? S_RUN : S_IDLE;
                end else begin
                    st_ra   = r_k - AW'(1);
                    n_state = S_INS_CM;
                end
            end
            S_INS_CM: begin
                st_we = 1'b1;
                st_wa = r_k;
                if (r_store_q[23:0] > r_s) begin
                    st_wd   = r_store_q;
                    n_k     = r_k - AW'(1);
                    n_state = S_INS_RD;
                end else begin
                    st_wd   = {r_w, r_s};
                    n_count = r_count + CW'(1);
                    n_state = r_last ? S_RUN : S_IDLE;
                end
            end
            S_RUN: begin
                dp_we   = 1'b1;
                dp_wd   = {1'b1, 24'd0};
                n_i     = '0;
                n_best  = '0;
                n_state = (r_count == '0) ? S_DONE : S_LD;
            end
            S_LD: begin
                st_ra   = r_i;
                n_state = S_LD2;
            end
            S_LD2: begin
                n_w     = r_store_q[47:24];
                n_s     = r_store_q[23:0];
                n_j     = CW'(r_i) + CW'(1);
                n_cur   = '0;
                dp_ra   = CW'(r_i);
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                dp_we = 1'b1;
                dp_wa = r_j;
                dp_wd = dp_new;
                if (dp_new[24] && (r_j > r_best)) begin
                    n_best = r_j;
                end
                n_cur = r_dp_q;
                if (r_j == CW'(1)) begin
                    if (CW'(r_i) + CW'(1) == r_count) begin
                        n_state = S_DONE;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = S_LD;
                    end
                end else begin
                    n_j   = r_j - CW'(1);
                    dp_ra = r_j - CW'(2);
                end
            end
            S_DONE: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = '{stack_count: best_wide[10:0], overflow: r_ovf};
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;  r_s <= n_s;  r_last <= n_last;
        r_k <= n_k;  r_i <= n_i;  r_j <= n_j;
        r_cur <= n_cur;  r_best <= n_best;  r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the stacking tower unit.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cstk_pkg::*;

    localparam int MAX_N     = DEF_MAX_ITEMS;
    localparam int WDOG_MAX  = 2000000;  // idle cycles
    localparam int DRAIN_CYC = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      pop = 1'b0;
    logic      empty;
    t_out_item o_result;

    capacity_stack_max_count_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the block's item store and set status.
    int unsigned weight_mem [MAX_N];
    int unsigned strength_mem [MAX_N];
    int unsigned set_len;
    bit          set_overflow;

    t_out_item height_q [$];  // expected results, oldest first
    int        err_cnt = 0;
    int        idle_pct;      // sender idle chance, percent
    int        stall_pct;     // receiver stall chance, percent
    int        wdog = 0;

    // Stable insertion sort on strength, then least weight per height.
    function automatic int tallest_stack(int unsigned n);
        int unsigned sw, ss, k, sum;
        int unsigned least [MAX_N + 1];
        bit          ok [MAX_N + 1];
        int          best;
        best = 0;
        for (int unsigned i = 1; i < n; i++) begin
            ss = strength_mem[i];
            sw = weight_mem[i];
            k  = i;
            while (k > 0 && strength_mem[k-1] > ss) begin
                strength_mem[k] = strength_mem[k-1];
                weight_mem[k]   = weight_mem[k-1];
                k--;
            end
            strength_mem[k] = ss;
            weight_mem[k]   = sw;
        end
        for (int j = 0; j <= n; j++) begin
            ok[j] = (j == 0);
            least[j] = 0;
        end
        for (int unsigned i = 0; i < n; i++) begin
            for (int j = i + 1; j >= 1; j--) begin
                if (ok[j-1]) begin
                    sum = least[j-1] + weight_mem[i];
                    if (sum <= strength_mem[i] && (!ok[j] || sum < least[j])) begin
                        least[j] = sum;
                        ok[j]    = 1'b1;
                    end
                end
            end
        end
        for (int j = 0; j <= n; j++)
            if (ok[j]) best = j;
        return best;
    endfunction

    // Update the shadow state with an accepted request; returns 1 on end of set.
    function automatic bit accept_item(t_in_item it, output t_out_item res);
        res = '0;
        if (set_len < MAX_N) begin
            weight_mem[set_len]   = it.item_weight;
            strength_mem[set_len] = it.item_strength;
            set_len++;
        end else begin
            set_overflow = 1'b1;
        end
        if (!it.last_item) return 1'b0;
        res.stack_count = 11'(tallest_stack(set_len));
        res.overflow    = set_overflow;
        set_len      = 0;
        set_overflow = 1'b0;
        return 1'b1;
    endfunction

    // Push one request, idling at random first; push stays high until taken.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    // Send one request and, at the end of a set, queue the predictor's answer.
    task automatic send_checked(t_in_item it);
        t_out_item res;
        send_item(it);
        if (accept_item(it, res)) height_q = {height_q, res};
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    // Receiver: pop held low at random.
    always @(negedge i_clk)
        pop <= ($urandom_range(99) >= stall_pct);

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) wdog <= 0;
            else wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("watchdog: no request or result moved for %0d cycles", wdog);
                $display("DONE: errors detected");
                $finish;
            end
            if (pop && !empty) begin
                if (height_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result count=%0d ovf=%0b",
                                 o_result.stack_count, o_result.overflow);
                end else begin
                    t_out_item want;
                    want = height_q.pop_front();
                    if (o_result.stack_count !== want.stack_count ||
                        o_result.overflow !== want.overflow) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: count exp %0d got %0d, ovf exp %0b got %0b",
                                     want.stack_count, o_result.stack_count,
                                     want.overflow, o_result.overflow);
                    end
                end
            end
        end
    end

    // Directed rows: a typed answer where it is obvious, else the predictor's.
    typedef struct {
        logic [23:0] w;
        logic [23:0] s;
        bit          last;
        bit          typed;
        int          count;
        bit          ovf;
    } t_row;

    t_row rows [] = '{
        '{24'd1,        24'd0,        1, 1, 0, 0},  // too weak for itself
        '{24'd1,        24'd1,        1, 1, 1, 0},  // exactly bears itself
        '{24'hFFFFFF,   24'hFFFFFF,   1, 1, 1, 0},  // field maxima
        '{24'd0,        24'd0,        1, 1, 1, 0},  // zero weight fits
        '{24'd5,        24'd10,       0, 0, 0, 0},
        '{24'd5,        24'd5,        0, 0, 0, 0},
        '{24'd5,        24'd15,       1, 1, 3, 0},  // out-of-order strengths
        '{24'd3,        24'd6,        0, 0, 0, 0},
        '{24'd3,        24'd6,        1, 1, 2, 0},  // equal strengths
        '{24'hFFFFFF,   24'hFFFFFF,   0, 0, 0, 0},
        '{24'd1,        24'hFFFFFF,   1, 1, 1, 0},  // sum past strength
        '{24'h800000,   24'hAAAAAA,   0, 0, 0, 0},
        '{24'h555555,   24'h555555,   0, 0, 0, 0},
        '{24'd7,        24'd3,        1, 0, 0, 0}
    };

    task automatic random_set(int len);
        t_in_item it;
        bit       tiny;
        tiny = ($urandom_range(3) != 0);
        for (int k = 0; k < len; k++) begin
            if (tiny) begin
                it.item_weight   = 24'($urandom_range(1, 60));
                it.item_strength = 24'($urandom_range(0, 400));
            end else begin
                it.item_weight   = 24'($urandom_range(1, 24'hFFFFFF));
                it.item_strength = 24'($urandom);
            end
            it.last_item = (k == len - 1);
            send_checked(it);
        end
    endtask

    task automatic drain();
        while (height_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    initial begin
        t_in_item  it;
        t_out_item res;
        int        sent;
        int        len;
        set_len = 0;
        set_overflow = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            it.item_weight   = rows[r].w;
            it.item_strength = rows[r].s;
            it.last_item     = rows[r].last;
            send_item(it);
            if (accept_item(it, res)) begin
                if (rows[r].typed) begin
                    res.stack_count = 11'(rows[r].count);
                    res.overflow    = rows[r].ovf;
                end
                height_q = {height_q, res};
            end
        end
        end_burst();
        drain();

        // Random sets, one phase per idling mix.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            sent = 0;
            while (sent < 138) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
                random_set(len);
                sent += len;
            end
            end_burst();
            drain();
        end

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+sv
sv/cstk_pkg.sv
sv/cstk_front.sv
sv/cstk_fifo.sv
sv/cstk_back.sv
sv/capacity_stack_max_count_unit.sv
tb/sv/tb_top.sv
